/* rtl/core/ptha_pkg.sv */
// Types, codes and score arithmetic shared by the probed hash table blocks.
// No dependencies.
package ptha_pkg;

   localparam logic OP_RETRIEVE = 1'b0;
   localparam logic OP_STORE    = 1'b1;

   localparam logic CSR_LOOKUP_ENABLE  = 1'b0;
   localparam logic CSR_MATE_THRESHOLD = 1'b1;

   localparam int   CSR_WIDTH          = 15;
   localparam logic LOOKUP_ENABLE_RST  = 1'b1;
   localparam logic [14:0] MATE_THRESHOLD_RST = 15'd30000;
   localparam int   REPL_WIDTH         = 15;

   typedef struct packed {
      logic               opcode;
      logic [63:0]        lookup_key;
      logic [5:0]         search_age;
      logic [7:0]         ply_distance;
      logic [7:0]         search_depth;
      logic signed [15:0] entry_score;
      logic [15:0]        entry_move;
      logic [1:0]         bound_flags;
   } req_type;

   typedef struct packed {
      logic               found;
      logic               deep_enough;
      logic signed [15:0] found_score;
      logic [15:0]        found_move;
      logic [1:0]         found_flags;
   } rsp_type;

   typedef struct packed {
      logic [63:0]        key;
      logic [5:0]         age;
      logic [7:0]         depth;
      logic [1:0]         flags;
      logic [15:0]        move;
      logic signed [15:0] score;
   } entry_type;

   typedef struct packed {
      logic                  match;
      logic                  deep;
      logic [REPL_WIDTH-1:0] repl_score;
   } eval_type;

   typedef struct packed {
      logic we;
      logic re;
   } mem_ctl_type;

   function automatic logic signed [15:0] adjust_score(
      input logic signed [15:0] score,
      input logic [14:0]        thr,
      input logic [7:0]         ply,
      input logic               away);
      logic signed [17:0] v;
      logic signed [17:0] t;
      logic signed [17:0] p;
      logic signed [17:0] r;
      v = {{2{score[15]}}, score};
      t = signed'({3'b000, thr});
      p = signed'({10'd0, ply});
      r = v;
      if (v > t) begin
         r = away ? v + p : v - p;
      end else if (v < -t) begin
         r = away ? v - p : v + p;
      end
      if (r > 18'sd32767) begin
         r = 18'sd32767;
      end else if (r < -18'sd32767) begin
         r = -18'sd32767;
      end
      return r[15:0];
   endfunction

endpackage

/* rtl/core/ptha_table_mem.sv */
// Slot memory: one write port and one registered read port.
// Depends on ptha_pkg.
module ptha_table_mem
   import ptha_pkg::*;
#(
   parameter int ENTRIES = 1024,
   parameter int AW      = $clog2(ENTRIES)
) (
   input  logic        clock,
   input  mem_ctl_type ctl,
   input  logic [AW-1:0] wr_addr,
   input  entry_type   wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type   rd_data
);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ptha_slot_eval.sv */
// Shared slot evaluator: key match, depth check and replacement score.
// Depends on ptha_pkg.
module ptha_slot_eval
   import ptha_pkg::*;
(
   input  entry_type   slot,
   input  logic [63:0] key,
   input  logic [5:0]  age,
   input  logic [7:0]  depth,
   output eval_type    result
);

   logic [5:0] diff;
   logic [5:0] age_gap;
   logic [8:0] depth_part;

   always_comb begin
      diff = age - slot.age;
      priority if (diff == 6'd0) begin
         age_gap = 6'd0;
      end else if (age > slot.age) begin
         age_gap = diff;
      end else begin
         age_gap = diff - 6'd1;
      end
      depth_part        = 9'd256 - {1'b0, slot.depth};
      result.match      = (slot.key == key);
      result.deep       = (slot.depth >= depth);
      result.repl_score = REPL_WIDTH'({age_gap, 8'h00}) + REPL_WIDTH'(depth_part);
   end

endmodule

/* rtl/core/probed_hash_table_age_depth_replace_unit.sv */
// Probed hash table with age/depth replacement, top level and sequencer.
// Depends on ptha_pkg, ptha_table_mem and ptha_slot_eval.
//
// After reset the block clears its table, one slot a cycle, with busy
// high. Each operation then runs through ST_PROBE and ST_FINISH before
// the next one is accepted: the table's single read port delivers one
// probed slot a cycle to a shared evaluator, the last slot arrives in
// the cycle after its address, the closing state writes the chosen slot
// on a store and forms the result, and the next word is taken in the
// cycle the result is out. The result word sits on rsp_data for the one
// cycle rsp_valid is high, in which busy is already low; the receiver
// cannot stall and must take it then.
module probed_hash_table_age_depth_replace_unit
   import ptha_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024,
   parameter int PROBE_COUNT   = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_type              req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(PROBE_COUNT + 1);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_PROBE  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   req_type          req_ff, req_in;
   logic [CW-1:0]    iss_cnt_ff, iss_cnt_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_last_ff, rd_last_in;
   logic [AW-1:0]    rd_slot_ff, rd_slot_in;
   logic             hit_ff, hit_in;
   logic             have_best_ff, have_best_in;
   logic [REPL_WIDTH-1:0] best_ff, best_in;
   logic [AW-1:0]    victim_ff, victim_in;
   entry_type        hit_entry_ff, hit_entry_in;
   logic             hit_deep_ff, hit_deep_in;
   logic             rsp_vld_ff, rsp_vld_in;
   rsp_type          rsp_ff, rsp_in;
   logic             enable_ff, enable_in;
   logic [14:0]      thr_ff, thr_in;

   mem_ctl_type      mem_ctl;
   logic [AW-1:0]    mem_wr_addr;
   entry_type        mem_wr_data;
   logic [AW-1:0]    mem_rd_addr;
   entry_type        mem_rd_data;
   eval_type         ev;
   logic             issue;

   ptha_table_mem #(
      .ENTRIES (TABLE_ENTRIES),
      .AW      (AW)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ptha_slot_eval u_eval (
      .slot   (mem_rd_data),
      .key    (req_ff.lookup_key),
      .age    (req_ff.search_age),
      .depth  (req_ff.search_depth),
      .result (ev)
   );

   always_comb begin
      enable_in = enable_ff;
      thr_in    = thr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LOOKUP_ENABLE:  enable_in = csr_wdata[0];
            CSR_MATE_THRESHOLD: thr_in    = csr_wdata[14:0];
            default:            thr_in    = thr_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      req_in       = req_ff;
      iss_cnt_in   = iss_cnt_ff;
      rd_vld_in    = 1'b0;
      rd_last_in   = 1'b0;
      rd_slot_in   = rd_slot_ff;
      hit_in       = hit_ff;
      have_best_in = have_best_ff;
      best_in      = best_ff;
      victim_in    = victim_ff;
      hit_entry_in = hit_entry_ff;
      hit_deep_in  = hit_deep_ff;
      rsp_vld_in   = 1'b0;
      rsp_in       = rsp_ff;
      mem_ctl      = '0;
      mem_wr_addr  = victim_ff;
      mem_wr_data  = '0;
      mem_rd_addr  = req_ff.lookup_key[AW-1:0] + AW'(iss_cnt_ff);
      issue        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctl.we  = 1'b1;
            mem_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(TABLE_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in       = req_data;
               iss_cnt_in   = '0;
               hit_in       = 1'b0;
               have_best_in = 1'b0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            issue = (iss_cnt_ff != CW'(PROBE_COUNT));
            if (issue) begin
               mem_ctl.re = 1'b1;
               iss_cnt_in = iss_cnt_ff + CW'(1);
               rd_vld_in  = 1'b1;
               rd_last_in = (iss_cnt_ff == CW'(PROBE_COUNT - 1));
               rd_slot_in = mem_rd_addr;
            end
            if (rd_vld_ff && !hit_ff) begin
               priority if (ev.match) begin
                  hit_in       = 1'b1;
                  victim_in    = rd_slot_ff;
                  hit_entry_in = mem_rd_data;
                  hit_deep_in  = ev.deep;
               end else if (!have_best_ff || (ev.repl_score > best_ff)) begin
                  have_best_in = 1'b1;
                  best_in      = ev.repl_score;
                  victim_in    = rd_slot_ff;
               end else begin
                  victim_in    = victim_ff;
               end
            end
            if (rd_vld_ff && rd_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_vld_in = 1'b1;
            rsp_in     = '0;
            if (req_ff.opcode == OP_STORE) begin
               mem_ctl.we        = 1'b1;
               mem_wr_data.key   = req_ff.lookup_key;
               mem_wr_data.age   = req_ff.search_age;
               mem_wr_data.depth = req_ff.search_depth;
               mem_wr_data.flags = req_ff.bound_flags;
               mem_wr_data.move  = req_ff.entry_move;
               mem_wr_data.score = adjust_score(req_ff.entry_score, thr_ff,
                                                req_ff.ply_distance, 1'b1);
            end else if (enable_ff && hit_ff) begin
               rsp_in.found       = 1'b1;
               rsp_in.deep_enough = hit_deep_ff;
               rsp_in.found_score = adjust_score(hit_entry_ff.score, thr_ff,
                                                 req_ff.ply_distance, 1'b0);
               rsp_in.found_move  = hit_entry_ff.move;
               rsp_in.found_flags = hit_entry_ff.flags;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         rd_vld_ff   <= 1'b0;
         rd_last_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         enable_ff   <= LOOKUP_ENABLE_RST;
         thr_ff      <= MATE_THRESHOLD_RST;
         iss_cnt_ff  <= '0;
         hit_ff      <= 1'b0;
         have_best_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         rd_vld_ff   <= rd_vld_in;
         rd_last_ff  <= rd_last_in;
         rsp_vld_ff  <= rsp_vld_in;
         enable_ff   <= enable_in;
         thr_ff      <= thr_in;
         iss_cnt_ff  <= iss_cnt_in;
         hit_ff      <= hit_in;
         have_best_ff <= have_best_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rd_slot_ff   <= rd_slot_in;
      best_ff      <= best_in;
      victim_ff    <= victim_in;
      hit_entry_ff <= hit_entry_in;
      hit_deep_ff  <= hit_deep_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> $past(state_ff == ST_FINISH))
      else $error("result strobe without a closing cycle");

   a_no_write_in_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> !mem_ctl.we)
      else $error("table write while probing");

   a_store_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (req_ff.opcode == OP_STORE)) |-> (rsp_ff == '0))
      else $error("store produced a nonzero result");

   a_deep_needs_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.deep_enough) |-> rsp_ff.found)
      else $error("deep_enough without found");

endmodule

/* tb/probed_hash_table_age_depth_replace_unit_tb.sv */
// Self-checking bench for the probed hash table: directed and random words are
// checked against an in-bench mirror of the table and its two registers.
// Depends on ptha_pkg and probed_hash_table_age_depth_replace_unit.
module probed_hash_table_age_depth_replace_unit_tb;
   import ptha_pkg::*;

   localparam int ENTRIES  = 1024;
   localparam int PROBES   = 4;
   localparam int KEY_POOL = 32;
   localparam int HOMES [8] = '{0, 1, 1023, 1022, 300, 302, 500, 700};

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   req_type              req_data  = '0;
   logic                 busy;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic                 csr_index = CSR_LOOKUP_ENABLE;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   entry_type   slot_mirror [ENTRIES];
   logic        lookup_on;
   int          mate_thr;
   rsp_type     pending_rsp [$];
   logic [63:0] key_pool [KEY_POOL];
   logic [5:0]  gen_age    = '0;
   int          burst_left = 0;
   int          errors     = 0;
   int          words      = 0;
   int          stores     = 0;
   int          hits       = 0;
   int          deep_hits  = 0;
   int          csr_writes = 0;

   probed_hash_table_age_depth_replace_unit #(
      .TABLE_ENTRIES(ENTRIES),
      .PROBE_COUNT  (PROBES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d words outstanding", pending_rsp.size());
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int sat_score(int v);
      if (v > 32767) return 32767;
      if (v < -32767) return -32767;
      return v;
   endfunction

   // Apply one word to the mirror and return the word the block must answer with.
   function automatic rsp_type table_apply(req_type w);
      rsp_type   r;
      entry_type e;
      int        i, home, s, d, repl, best, victim, v, ply;
      r      = '0;
      ply    = int'(w.ply_distance);
      home   = int'(w.lookup_key & 64'(ENTRIES - 1));
      victim = home;
      best   = -1000000;
      if (w.opcode == OP_STORE) begin
         v = int'(w.entry_score);
         if (v > mate_thr) begin
            v = sat_score(v + ply);
         end else if (v < -mate_thr) begin
            v = sat_score(v - ply);
         end else begin
            v = sat_score(v);
         end
         for (i = 0; i < PROBES; i++) begin
            s = (home + i) & (ENTRIES - 1);
            if (slot_mirror[s].key == w.lookup_key) begin
               victim = s;
               break;
            end
            d    = int'(w.search_age) - int'(slot_mirror[s].age);
            repl = 256 - int'(slot_mirror[s].depth);
            if (d > 0) begin
               repl += d * 256;
            end else if (d < 0) begin
               repl += (63 + d) * 256;
            end
            if (repl > best) begin
               best   = repl;
               victim = s;
            end
         end
         e.key   = w.lookup_key;
         e.age   = w.search_age;
         e.depth = w.search_depth;
         e.flags = w.bound_flags;
         e.move  = w.entry_move;
         e.score = v[15:0];
         slot_mirror[victim] = e;
      end else if (lookup_on) begin
         for (i = 0; i < PROBES; i++) begin
            s = (home + i) & (ENTRIES - 1);
            if (slot_mirror[s].key == w.lookup_key) begin
               v = int'(slot_mirror[s].score);
               if (v > mate_thr) begin
                  v = sat_score(v - ply);
               end else if (v < -mate_thr) begin
                  v = sat_score(v + ply);
               end else begin
                  v = sat_score(v);
               end
               r.found       = 1'b1;
               r.deep_enough = slot_mirror[s].depth >= w.search_depth;
               r.found_score = v[15:0];
               r.found_move  = slot_mirror[s].move;
               r.found_flags = slot_mirror[s].flags;
               break;
            end
         end
      end
      return r;
   endfunction

   function automatic req_type make_word(logic op, logic [63:0] key, int age, int ply,
                                         int depth, int score, int move, int flags);
      req_type w;
      w.opcode       = op;
      w.lookup_key   = key;
      w.search_age   = age[5:0];
      w.ply_distance = ply[7:0];
      w.search_depth = depth[7:0];
      w.entry_score  = score[15:0];
      w.entry_move   = move[15:0];
      w.bound_flags  = flags[1:0];
      return w;
   endfunction

   function automatic req_type noise_word();
      logic [127:0] b;
      b = {$urandom, $urandom, $urandom, $urandom};
      return b[$bits(req_type)-1:0];
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      pick, v;
      w.opcode = ($urandom_range(0, 99) < 45) ? OP_STORE : OP_RETRIEVE;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         w.lookup_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      end else if (pick < 90) begin
         w.lookup_key = '0;
      end else begin
         w.lookup_key = {$urandom, $urandom};
      end
      if ($urandom_range(0, 4) == 0) begin
         w.search_age = 6'($urandom_range(0, 63));
      end else begin
         w.search_age = gen_age - 6'($urandom_range(0, 2));
      end
      w.ply_distance = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) begin
         w.search_depth = 8'($urandom_range(0, 15));
      end else begin
         w.search_depth = 8'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 5))
         0: v = int'($urandom_range(0, 2000)) - 1000;
         1: v = mate_thr + int'($urandom_range(0, 400)) - 100;
         2: v = -mate_thr - int'($urandom_range(0, 400)) + 100;
         3: begin
            case ($urandom_range(0, 2))
               0: v = 32767;
               1: v = -32767;
               default: v = -32768;
            endcase
         end
         default: v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      w.entry_score = v[15:0];
      w.entry_move  = 16'($urandom_range(0, 65535));
      w.bound_flags = 2'($urandom_range(0, 3));
      return w;
   endfunction

   // Hold start until the word is taken, then idle for a random gap, which is zero within a burst.
   task automatic send_word(req_type w);
      rsp_type want;
      int      gap;
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = table_apply(w);
      pending_rsp.push_back(want);
      words++;
      if (w.opcode == OP_STORE) stores++;
      if (want.found) hits++;
      if (want.deep_enough) deep_hits++;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 19);
         if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start    <= 1'b0;
         req_data <= noise_word();
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (busy || pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int value);
      hold_until_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_WIDTH-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LOOKUP_ENABLE) begin
         lookup_on = value[0];
      end else begin
         mate_thr = value & 32'h7FFF;
      end
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic run_random(int count);
      int n;
      for (n = 0; n < count; n++) begin
         send_word(random_word());
         if ($urandom_range(0, 29) == 0) gen_age++;
         if ($urandom_range(0, 199) == 0) hold_until_drained();
      end
   endtask

   task automatic test_directed();
      logic [63:0] k1, k2, k3, k4, k5;
      k1 = '1;
      k2 = 64'h5A5A_0F0F_3C3C_07FF;
      k3 = 64'h0123_4567_89AB_CFFF;
      k4 = 64'h8000_0000_0000_03FF;
      k5 = 64'h7FFF_FFFF_FFFF_FBFF;
      send_word(make_word(OP_RETRIEVE, '0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_RETRIEVE, '0, 0, 0, 255, 0, 0, 0));
      send_word(make_word(OP_RETRIEVE, k1, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_STORE, k1, 63, 255, 255, 32767, 16'hFFFF, 3));
      send_word(make_word(OP_RETRIEVE, k1, 0, 0, 255, 0, 0, 0));
      send_word(make_word(OP_RETRIEVE, k1, 0, 255, 0, 0, 0, 0));
      send_word(make_word(OP_STORE, k2, 0, 255, 0, -32768, 0, 0));
      send_word(make_word(OP_RETRIEVE, k2, 0, 1, 1, 0, 0, 0));
      send_word(make_word(OP_STORE, k3, 5, 10, 10, 30000, 16'h1234, 1));
      send_word(make_word(OP_STORE, k4, 5, 10, 20, 30001, 16'hABCD, 2));
      send_word(make_word(OP_STORE, k5, 6, 3, 1, -30001, 16'h0F0F, 3));
      send_word(make_word(OP_RETRIEVE, k1, 0, 7, 200, 0, 0, 0));
      send_word(make_word(OP_RETRIEVE, k2, 0, 7, 0, 0, 0, 0));
      send_word(make_word(OP_RETRIEVE, k3, 0, 7, 10, 0, 0, 0));
      send_word(make_word(OP_RETRIEVE, k4, 0, 7, 21, 0, 0, 0));
      send_word(make_word(OP_RETRIEVE, k5, 0, 7, 1, 0, 0, 0));
      send_word(make_word(OP_STORE, k3, 7, 0, 0, -29999, 16'h8001, 2));
      send_word(make_word(OP_RETRIEVE, k3, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_STORE, '0, 1, 20, 0, -31000, 16'h00FF, 1));
      send_word(make_word(OP_RETRIEVE, '0, 0, 20, 0, 0, 0, 0));
      send_word(make_word(OP_RETRIEVE, '0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random_defaults();
      run_random(600);
   endtask

   task automatic test_lookup_disabled();
      logic [63:0] k;
      k = 64'hC0DE_0000_1111_012C;
      write_csr(CSR_LOOKUP_ENABLE, 0);
      send_word(make_word(OP_STORE, k, 9, 4, 9, 31000, 16'h4242, 1));
      send_word(make_word(OP_RETRIEVE, k, 0, 4, 0, 0, 0, 0));
      run_random(150);
      write_csr(CSR_LOOKUP_ENABLE, 1);
      send_word(make_word(OP_RETRIEVE, k, 0, 4, 0, 0, 0, 0));
   endtask

   task automatic test_threshold_extremes();
      write_csr(CSR_MATE_THRESHOLD, 0);
      run_random(300);
      write_csr(CSR_MATE_THRESHOLD, 32767);
      run_random(300);
   endtask

   task automatic test_threshold_random();
      int n;
      for (n = 0; n < 4; n++) begin
         write_csr(CSR_MATE_THRESHOLD, $urandom_range(0, 32767));
         run_random(100);
      end
      write_csr(CSR_MATE_THRESHOLD, int'(MATE_THRESHOLD_RST));
   endtask

   task automatic flag_mismatch(string field, logic signed [31:0] exp,
                                logic signed [31:0] act);
      $display("%0t: %s expected %0d, got %0d", $time, field, exp, act);
      errors++;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.found !== want.found)
               flag_mismatch("found", want.found, rsp_data.found);
            if (rsp_data.deep_enough !== want.deep_enough)
               flag_mismatch("deep_enough", want.deep_enough, rsp_data.deep_enough);
            if (rsp_data.found_score !== want.found_score)
               flag_mismatch("found_score", $signed(want.found_score),
                             $signed(rsp_data.found_score));
            if (rsp_data.found_move !== want.found_move)
               flag_mismatch("found_move", want.found_move, rsp_data.found_move);
            if (rsp_data.found_flags !== want.found_flags)
               flag_mismatch("found_flags", want.found_flags, rsp_data.found_flags);
         end
      end
   end

   initial begin
      int k;
      for (k = 0; k < ENTRIES; k++) slot_mirror[k] = '0;
      lookup_on = LOOKUP_ENABLE_RST;
      mate_thr  = int'(MATE_THRESHOLD_RST);
      for (k = 0; k < KEY_POOL; k++) begin
         key_pool[k]       = {$urandom, $urandom};
         key_pool[k][9:0]  = 10'(HOMES[k % 8]);
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      hold_until_drained();
      test_directed();
      test_random_defaults();
      test_lookup_disabled();
      test_threshold_extremes();
      test_threshold_random();
      hold_until_drained();
      repeat (4 * (PROBES + 3)) @(posedge clock);
      $display("Covered %0d words: %0d stores, %0d retrieve hits (%0d deep enough).",
               words, stores, hits, deep_hits);
      $display("Register writes: %0d, lookup on and off, thresholds 0 to 32767.",
               csr_writes);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
